@@ design/grvf_pkg.sv @@
// ----------------------------------------------------------------------------
// grvf_pkg - shared constants, types and helpers for the root vertex finder
// Vertex limits, field widths, sequencer states and small bit helpers.
// ----------------------------------------------------------------------------
package grvf_pkg;

    localparam int C_MAX_VTX = 8;                      // vertices the store holds
    localparam int C_IDX_W   = $clog2(C_MAX_VTX);      // vertex index width
    localparam int C_CNT_W   = C_IDX_W + 1;            // holds 0..C_MAX_VTX
    localparam int C_CFG_W   = 4;                      // vertex_count register width
    localparam int C_ROOTS_W = 2;                      // root tally, saturates at 2

    typedef enum logic [2:0] {
        S_LOAD,     // taking edges
        S_INIT,     // copy adjacency plus self bit into reach store
        S_KROW,     // read pivot row k
        S_KCAP,     // capture pivot row
        S_UPD,      // sweep rows, merge pivot row where bit k is set
        S_SCAN,     // look for rows that reach every vertex
        S_FIN,      // last scan row settles
        S_DONE      // hand result to output register, clear adjacency
    } t_state;

    typedef enum logic [1:0] {
        WB_NONE,
        WB_INIT,
        WB_UPD,
        WB_SCAN
    } t_wb_kind;

    // vertex count in force, values above the limit act as the limit
    function automatic logic [C_CNT_W-1:0] vtx_clip(input logic [C_CFG_W-1:0] v);
        if (v > C_CFG_W'(C_MAX_VTX)) begin
            return C_CNT_W'(C_MAX_VTX);
        end else begin
            return C_CNT_W'(v);
        end
    endfunction

    // one bit per vertex in use
    function automatic logic [C_MAX_VTX-1:0] vtx_mask(input logic [C_CNT_W-1:0] n);
        logic [C_MAX_VTX-1:0] m;
        m = '0;
        for (int b = 0; b < C_MAX_VTX; b++) begin
            m[b] = (C_CNT_W'(b) < n);
        end
        return m;
    endfunction

    function automatic logic [C_MAX_VTX-1:0] vtx_onehot(input logic [C_IDX_W-1:0] i);
        return C_MAX_VTX'(1) << i;
    endfunction

endpackage

@@ design/grvf_ram.sv @@
// ----------------------------------------------------------------------------
// grvf_ram - generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module grvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];   // old data on a same-address collision
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/graph_root_vertex_finder_unit.sv @@
// ----------------------------------------------------------------------------
// graph_root_vertex_finder_unit - unique root (mother vertex) search
// Loads directed edges into an adjacency RAM, forms the transitive closure
// in a reach RAM after the last edge, and reports the single root, if any.
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake              payload
//  s_axis     in   tvalid/tready          tdata[2:0] edge_source, [5:3] edge_target,
//                                         tlast last_edge
//  m_axis     out  tvalid/tready          tdata[0] unique_root_found,
//                                         [3:1] root_index
//  cfg        in   wr_en (no wait)        wr_data[3:0] vertex_count
//
//  Edges are taken one per cycle; each edge is a read-modify-write of one
//  adjacency row, overlapped with the next edge through a one-deep bypass.
//  After the last edge the search is paced by the single read port of
//  the reach RAM: one row per cycle, plus a fetch and capture of row k
//  for each pivot (states S_KROW and S_KCAP).
//  No edges are taken during the search. The result sits in an output
//  register, so loading of the next graph starts while it waits; a second
//  search holds at its end until that register is free.
//  Reset (synchronous, active low) clears control state, the adjacency valid
//  bits and sets vertex_count to 8; RAM contents are not cleared.
//
module graph_root_vertex_finder_unit
    import grvf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // edge stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,     // [2:0] edge_source, [5:3] edge_target
    input  logic       i_s_axis_tlast,     // last_edge
    // result stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,     // [0] unique_root_found, [3:1] root_index
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data       // vertex_count
);

    // ---------------------------------------------------------------- state
    t_state                r_state, n_state;
    logic [C_CFG_W-1:0]    r_vertex_count;

    logic [C_CNT_W-1:0]    r_n, n_n;           // vertices in use for the search
    logic [C_MAX_VTX-1:0]  r_all, n_all;       // mask of those vertices
    logic [C_CNT_W-1:0]    r_i, n_i;           // row counter
    logic [C_CNT_W-1:0]    r_k, n_k;           // pivot counter
    logic [C_MAX_VTX-1:0]  r_rk;               // pivot row

    // edge load stage
    logic                  r_ld_vld;
    logic [C_IDX_W-1:0]    r_ld_src;
    logic [C_MAX_VTX-1:0]  r_ld_mask;
    logic [C_MAX_VTX-1:0]  r_adj_vld;          // rows written since last clear

    // bypass of the write made at the same edge as a read
    logic                  r_afw_vld;
    logic [C_IDX_W-1:0]    r_afw_addr;
    logic [C_MAX_VTX-1:0]  r_afw_data;
    logic                  r_rfw_vld;
    logic [C_IDX_W-1:0]    r_rfw_addr;
    logic [C_MAX_VTX-1:0]  r_rfw_data;
    logic [C_IDX_W-1:0]    r_adj_rd_addr;
    logic [C_IDX_W-1:0]    r_rch_rd_addr;

    // reach write-back stage
    t_wb_kind              r_wb_kind, n_wb_kind;
    logic [C_IDX_W-1:0]    r_wb_idx, n_wb_idx;
    logic [C_IDX_W-1:0]    r_wb_k;

    logic [C_ROOTS_W-1:0]  r_roots;
    logic [C_IDX_W-1:0]    r_root;

    // output register
    logic                  r_res_vld;
    logic                  r_res_found;
    logic [C_IDX_W-1:0]    r_res_root;

    // ------------------------------------------------------------ datapath
    logic                  in_acc;
    logic [C_IDX_W-1:0]    in_src, in_dst;
    logic [C_CNT_W-1:0]    n_cur;
    logic                  in_range;

    logic [C_IDX_W-1:0]    adj_raddr, rch_raddr;
    logic [C_MAX_VTX-1:0]  adj_rdata, rch_rdata;
    logic [C_MAX_VTX-1:0]  adj_row, rch_row;
    logic                  adj_we, rch_we;
    logic [C_MAX_VTX-1:0]  adj_wdata, rch_wdata;
    logic                  last_i, last_k, res_take, row_full;

    assign in_src   = i_s_axis_tdata[C_IDX_W-1:0];
    assign in_dst   = i_s_axis_tdata[2*C_IDX_W-1:C_IDX_W];
    assign n_cur    = vtx_clip(r_vertex_count);
    assign in_range = ({1'b0, in_src} < n_cur) && ({1'b0, in_dst} < n_cur);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign last_i   = (r_i == r_n - C_CNT_W'(1));
    assign last_k   = (r_k == r_n - C_CNT_W'(1));
    assign res_take = !r_res_vld || i_m_axis_tready;

    // row as last written: bypass, then never-written rows read as zero
    assign adj_row = (r_afw_vld && r_afw_addr == r_adj_rd_addr) ? r_afw_data :
                     (r_adj_vld[r_adj_rd_addr] ? adj_rdata : '0);
    assign rch_row = (r_rfw_vld && r_rfw_addr == r_rch_rd_addr) ? r_rfw_data : rch_rdata;

    assign adj_we    = r_ld_vld;
    assign adj_wdata = adj_row | r_ld_mask;

    assign row_full = ((rch_row & r_all) == r_all);

    always_comb begin
        rch_we    = 1'b0;
        rch_wdata = rch_row;
        case (r_wb_kind)
            WB_INIT: begin
                rch_we    = 1'b1;
                rch_wdata = (adj_row | vtx_onehot(r_wb_idx)) & r_all;
            end
            WB_UPD: begin
                rch_we    = 1'b1;
                rch_wdata = rch_row[r_wb_k] ? (rch_row | r_rk) : rch_row;
            end
            default: begin
                rch_we    = 1'b0;
            end
        endcase
    end

    grvf_ram #(.WIDTH(C_MAX_VTX), .DEPTH(C_MAX_VTX)) u_adj_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adj_we),
        .i_wr_addr (r_ld_src),
        .i_wr_data (adj_wdata),
        .i_rd_addr (adj_raddr),
        .o_rd_data (adj_rdata)
    );

    grvf_ram #(.WIDTH(C_MAX_VTX), .DEPTH(C_MAX_VTX)) u_rch_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rch_we),
        .i_wr_addr (r_wb_idx),
        .i_wr_data (rch_wdata),
        .i_rd_addr (rch_raddr),
        .o_rd_data (rch_rdata)
    );

    // ---------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (in_acc && i_s_axis_tlast) n_state = S_INIT;
            S_INIT: begin
                if (r_n == '0) begin
                    n_state = S_DONE;
                end else if (last_i) begin
                    n_state = S_KROW;
                end
            end
            S_KROW: n_state = S_KCAP;
            S_KCAP: n_state = S_UPD;
            S_UPD: begin
                if (last_i) n_state = last_k ? S_SCAN : S_KROW;
            end
            S_SCAN: if (last_i) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (res_take) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // ------------------------------------------------------ control outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        adj_raddr       = r_i[C_IDX_W-1:0];
        rch_raddr       = r_i[C_IDX_W-1:0];
        n_n             = r_n;
        n_all           = r_all;
        n_i             = r_i;
        n_k             = r_k;
        n_wb_kind       = WB_NONE;
        n_wb_idx        = r_i[C_IDX_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                o_s_axis_tready = 1'b1;
                adj_raddr       = in_src;
                if (in_acc && i_s_axis_tlast) begin
                    n_n   = n_cur;
                    n_all = vtx_mask(n_cur);
                    n_i   = '0;
                end
            end
            S_INIT: begin
                if (r_n != '0) begin
                    n_wb_kind = WB_INIT;
                    n_i       = last_i ? '0 : r_i + C_CNT_W'(1);
                    if (last_i) n_k = '0;
                end
            end
            S_KROW: begin
                rch_raddr = r_k[C_IDX_W-1:0];
            end
            S_UPD: begin
                n_wb_kind = WB_UPD;
                n_i       = last_i ? '0 : r_i + C_CNT_W'(1);
                if (last_i) n_k = r_k + C_CNT_W'(1);
            end
            S_SCAN: begin
                n_wb_kind = WB_SCAN;
                n_i       = last_i ? '0 : r_i + C_CNT_W'(1);
            end
            S_KCAP, S_FIN, S_DONE: begin
                n_wb_kind = WB_NONE;
            end
            default: begin
                n_wb_kind = WB_NONE;
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_vertex_count <= C_CFG_W'(C_MAX_VTX);
            r_ld_vld       <= 1'b0;
            r_adj_vld      <= '0;
            r_afw_vld      <= 1'b0;
            r_rfw_vld      <= 1'b0;
            r_wb_kind      <= WB_NONE;
            r_res_vld      <= 1'b0;
            r_n            <= '0;
            r_i            <= '0;
            r_k            <= '0;
            r_roots        <= '0;
        end else begin
            r_state   <= n_state;
            r_n       <= n_n;
            r_i       <= n_i;
            r_k       <= n_k;
            r_wb_kind <= n_wb_kind;
            if (i_cfg_wr_en) r_vertex_count <= i_cfg_wr_data;

            r_ld_vld <= in_acc && in_range;
            if (adj_we) r_adj_vld[r_ld_src] <= 1'b1;
            r_afw_vld <= adj_we;
            r_rfw_vld <= rch_we;

            if (r_state == S_LOAD && in_acc && i_s_axis_tlast) begin
                r_roots <= '0;
            end else if (r_wb_kind == WB_SCAN && row_full && r_roots != 2'd2) begin
                r_roots <= r_roots + 2'd1;
            end

            if (r_state == S_DONE && res_take) begin
                r_res_vld <= 1'b1;
                r_adj_vld <= '0;             // adjacency cleared for next graph
            end else if (i_m_axis_tready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_all         <= n_all;
        r_ld_src      <= in_src;
        r_ld_mask     <= vtx_onehot(in_dst);
        r_adj_rd_addr <= adj_raddr;
        r_rch_rd_addr <= rch_raddr;
        r_afw_addr    <= r_ld_src;
        r_afw_data    <= adj_wdata;
        r_rfw_addr    <= r_wb_idx;
        r_rfw_data    <= rch_wdata;
        r_wb_idx      <= n_wb_idx;
        r_wb_k        <= r_k[C_IDX_W-1:0];
        if (r_state == S_KCAP) r_rk <= rch_row;
        if (r_wb_kind == WB_SCAN && row_full) r_root <= r_wb_idx;
        if (r_state == S_DONE && res_take) begin
            r_res_found <= (r_roots == 2'd1);
            r_res_root  <= (r_roots == 2'd1) ? r_root : '0;
        end
    end

    assign o_m_axis_tvalid = r_res_vld;
    assign o_m_axis_tdata  = {4'b0000, r_res_root, r_res_found};

    // ----------------------------------------------------------- assertions
    // no edge write may still be pending once the closure sweep runs
    a_no_load_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD || r_state == S_SCAN || r_state == S_KROW) |-> !r_ld_vld)
        else $error("adjacency write during closure sweep");

    // row counter stays inside the vertices in use while sweeping
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD || r_state == S_SCAN) |-> (r_i < r_n))
        else $error("row counter beyond vertex count");

    // handing over a result leaves an empty adjacency store behind
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && res_take) |=> (r_adj_vld == '0 && r_res_vld))
        else $error("adjacency not cleared after result");

    // reach store is not written while edges are being loaded
    a_no_reach_wr_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !rch_we)
        else $error("reach write while loading edges");

endmodule
